FILE: design/csma_pkg.sv
// ============================================================================
// csma_pkg
// Shared widths, codes and defaults of the calibrated sensor moving average.
// ============================================================================
package csma_pkg;

  // Field widths of the words on the channels and the configuration port.
  localparam int OP_W        = 2;
  localparam int CH_W        = 3;
  localparam int TEMP_W      = 12;
  localparam int VALUE_W     = 13;
  localparam int ENTRY_W     = 4;
  localparam int OFFSET_W    = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  // Number of calibration offset registers and the bits that index them.
  localparam int NUM_OFFSETS = 5;
  localparam int OFS_IDX_W   = $clog2(NUM_OFFSETS);

  // Defaults of the top level parameters.
  localparam int DEF_CHANNELS   = 5;
  localparam int DEF_RING_DEPTH = 8;

  // Sentinel of -127 degrees in 1/16 degree units.
  localparam logic signed [VALUE_W-1:0] SENTINEL = VALUE_W'(-127 * 16);

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE     = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_EMULATE    = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_OFFSET_0 = 3'd0,
    CFG_CAL_OFFSET_1 = 3'd1,
    CFG_CAL_OFFSET_2 = 3'd2,
    CFG_CAL_OFFSET_3 = 3'd3,
    CFG_CAL_OFFSET_4 = 3'd4,
    CFG_EMULATE_MODE = 3'd5
  } cfg_idx_t;

endpackage

FILE: design/csma_if.sv
// ============================================================================
// csma_if
// Valid/ready channels carrying the input and result words.
// ============================================================================

// Input channel: one sensor item per word.
interface csma_in_if
  import csma_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [CH_W-1:0]            channel;
  logic signed [TEMP_W-1:0]   temperature;

  modport source (output valid, operation, channel, temperature, input ready);
  modport sink   (input valid, operation, channel, temperature, output ready);
endinterface

// Result channel: one channel update per word.
interface csma_out_if
  import csma_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            out_channel;
  logic signed [VALUE_W-1:0]  current_value;
  logic signed [VALUE_W-1:0]  average_value;
  logic [ENTRY_W-1:0]         entry_count;

  modport source (output valid, out_channel, current_value, average_value, entry_count,
                  input ready);
  modport sink   (input valid, out_channel, current_value, average_value, entry_count,
                  output ready);
endinterface

FILE: design/csma_ram.sv
// ============================================================================
// csma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module csma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/calibrated_sensor_moving_average.sv
// ============================================================================
// calibrated_sensor_moving_average
// Per-channel moving average of calibrated temperature readings.
// ============================================================================
// Each channel keeps a ring of up to RING_DEPTH corrected readings in a shared
// RAM, with its oldest pointer, fill count and running sum in registers that
// reset clears. An accepted word goes through S_UPDATE, S_MUL and S_OUT: the
// ring RAM is read in the acceptance cycle, the read-modify-write of the ring
// and the channel state happens in the next (S_UPDATE), the running sum is
// then multiplied by a reciprocal of the count (S_MUL), and the result word is
// loaded into the output register (S_OUT) once that register is free, after
// which the next word is accepted. A word that causes no result (sample or
// disconnect in emulate mode, unused operation, channel out of range) is
// dropped in its acceptance cycle. The ring RAM needs no clearing pass: an
// entry's read data is only used after the entry has been written.
module calibrated_sensor_moving_average
  import csma_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  csma_in_if.sink               in_word,
  csma_out_if.source            out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Derived widths.
  localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W     = VALUE_W + CNT_W;
  localparam int MAG_W     = SUM_W;
  localparam int SHIFT     = MAG_W + CNT_W;
  localparam int RECIP_W   = SHIFT + 1;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam int RAM_DEPTH = CHANNELS * RING_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_MUL    = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;

  // Configuration registers.
  logic signed [OFFSET_W-1:0]  cal_offset_r [NUM_OFFSETS];
  logic                        emulate_mode_r;

  // Per-channel ring bookkeeping.
  logic [PTR_W-1:0]            ptr_r [CHANNELS];
  logic [CNT_W-1:0]            cnt_r [CHANNELS];
  logic signed [SUM_W-1:0]     sum_r [CHANNELS];

  // Word being worked on.
  logic [OP_W-1:0]             op_r;
  logic [CHI_W-1:0]            ch_r;
  logic signed [VALUE_W-1:0]   corr_r;
  logic signed [VALUE_W-1:0]   cur_r;
  logic [MAG_W-1:0]            mag_r;
  logic                        neg_r;
  logic [CNT_W-1:0]            div_cnt_r;
  logic [PROD_W-1:0]           prod_r;

  // Output register.
  logic                        out_valid_r;
  logic [CH_W-1:0]             out_channel_r;
  logic signed [VALUE_W-1:0]   out_current_r;
  logic signed [VALUE_W-1:0]   out_average_r;
  logic [ENTRY_W-1:0]          out_entry_r;

  // Ring RAM ports.
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [VALUE_W-1:0]          ram_rdata;

  // Acceptance.
  logic                        in_fire;
  logic                        item_ok;
  logic [CHI_W-1:0]            in_chi;
  logic signed [VALUE_W-1:0]   corr_in;

  // Update arithmetic.
  logic [PTR_W-1:0]            ptr_cur, ptr_mid, ptr_inc;
  logic [CNT_W-1:0]            cnt_cur, cnt_mid, cnt_new;
  logic signed [SUM_W-1:0]     sum_cur, sum_mid, sum_new;
  logic signed [SUM_W-1:0]     rd_ext;
  logic                        do_drop, do_push;
  logic [CNT_W:0]              slot_sum;
  logic [PTR_W-1:0]            slot;

  // Division tail.
  logic [RECIP_W-1:0]          recip_tab [RING_DEPTH + 1];
  logic [VALUE_W-1:0]          quot;
  logic signed [VALUE_W-1:0]   avg;
  logic                        out_load;

  // Reciprocal table: ceil(2^SHIFT / n) gives an exact quotient for any
  // magnitude below 2^MAG_W and any count up to RING_DEPTH.
  assign recip_tab[0] = '0;
  for (genvar gi = 1; gi <= RING_DEPTH; gi++) begin : g_recip
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + gi - 1) / gi;
    assign recip_tab[gi] = RECIP_W'(RECIP);
  end

  // Input acceptance and the words that cause no result.
  assign in_word.ready = (state_r == S_IDLE);
  assign in_fire       = in_word.valid && in_word.ready;
  assign in_chi        = in_word.channel[CHI_W-1:0];
  assign item_ok       = (32'(in_word.channel) < CHANNELS)
                      && (in_word.operation != OP_UNUSED)
                      && (!emulate_mode_r || (in_word.operation == OP_EMULATE));
  assign corr_in       = VALUE_W'(in_word.temperature)
                       + VALUE_W'(cal_offset_r[in_word.channel[OFS_IDX_W-1:0]]);

  // Read the channel's oldest entry in the acceptance cycle.
  assign ram_re    = in_fire && item_ok;
  assign ram_raddr = ADDR_W'(ADDR_W'(in_chi) * ADDR_W'(RING_DEPTH) + ADDR_W'(ptr_r[in_chi]));

  // Ring update: drop the oldest entry where needed, then push.
  always_comb begin
    ptr_cur = ptr_r[ch_r];
    cnt_cur = cnt_r[ch_r];
    sum_cur = sum_r[ch_r];
    rd_ext  = SUM_W'($signed(ram_rdata));
    ptr_inc = (32'(ptr_cur) == RING_DEPTH - 1) ? '0 : PTR_W'(ptr_cur + 1'b1);
    do_drop = 1'b0;
    do_push = 1'b0;
    case (op_r)
      OP_EMULATE: begin
        do_push = 1'b1;
      end
      OP_SAMPLE: begin
        do_drop = (32'(cnt_cur) == RING_DEPTH);
        do_push = 1'b1;
      end
      OP_DISCONNECT: begin
        do_drop = (cnt_cur != '0);
      end
      default: begin
      end
    endcase
    if (op_r == OP_EMULATE) begin
      ptr_mid = '0;
      cnt_mid = '0;
      sum_mid = '0;
    end else if (do_drop) begin
      ptr_mid = ptr_inc;
      cnt_mid = CNT_W'(cnt_cur - 1'b1);
      sum_mid = SUM_W'(sum_cur - rd_ext);
    end else begin
      ptr_mid = ptr_cur;
      cnt_mid = cnt_cur;
      sum_mid = sum_cur;
    end
    // The new entry goes just past the newest one held.
    slot_sum = (CNT_W + 1)'(ptr_mid) + (CNT_W + 1)'(cnt_mid);
    if (32'(slot_sum) >= RING_DEPTH) begin
      slot = PTR_W'(slot_sum - (CNT_W + 1)'(RING_DEPTH));
    end else begin
      slot = PTR_W'(slot_sum);
    end
    if (do_push) begin
      cnt_new = CNT_W'(cnt_mid + 1'b1);
      sum_new = SUM_W'(sum_mid + SUM_W'(corr_r));
    end else begin
      cnt_new = cnt_mid;
      sum_new = sum_mid;
    end
  end

  assign ram_we    = (state_r == S_UPDATE) && do_push;
  assign ram_waddr = ADDR_W'(ADDR_W'(ch_r) * ADDR_W'(RING_DEPTH) + ADDR_W'(slot));

  csma_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (corr_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Quotient with truncation toward zero, sentinel for an empty ring.
  assign quot     = prod_r[SHIFT +: VALUE_W];
  assign avg      = (div_cnt_r == '0) ? SENTINEL
                  : (neg_r ? VALUE_W'(-quot) : VALUE_W'(quot));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_word.ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && item_ok) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and channel bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      emulate_mode_r <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NUM_OFFSETS; i++) begin
        cal_offset_r[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i] <= '0;
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAL_OFFSET_0: cal_offset_r[0] <= cfg_wdata;
          CFG_CAL_OFFSET_1: cal_offset_r[1] <= cfg_wdata;
          CFG_CAL_OFFSET_2: cal_offset_r[2] <= cfg_wdata;
          CFG_CAL_OFFSET_3: cal_offset_r[3] <= cfg_wdata;
          CFG_CAL_OFFSET_4: cal_offset_r[4] <= cfg_wdata;
          CFG_EMULATE_MODE: emulate_mode_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (state_r == S_UPDATE) begin
        ptr_r[ch_r] <= ptr_mid;
        cnt_r[ch_r] <= cnt_new;
        sum_r[ch_r] <= sum_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_word.operation;
      ch_r   <= in_chi;
      corr_r <= corr_in;
    end
    if (state_r == S_UPDATE) begin
      cur_r     <= (op_r == OP_DISCONNECT) ? SENTINEL : corr_r;
      neg_r     <= sum_new[SUM_W-1];
      mag_r     <= sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);
      div_cnt_r <= cnt_new;
    end
    if (state_r == S_MUL) begin
      prod_r <= mag_r * recip_tab[div_cnt_r];
    end
    if (out_load) begin
      out_channel_r <= CH_W'(ch_r);
      out_current_r <= cur_r;
      out_average_r <= avg;
      out_entry_r   <= ENTRY_W'(div_cnt_r);
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.out_channel   = out_channel_r;
  assign out_word.current_value = out_current_r;
  assign out_word.average_value = out_average_r;
  assign out_word.entry_count   = out_entry_r;

`ifndef SYNTHESIS
  // A word that acts starts the ring update in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && item_ok) |=> (state_r == S_UPDATE))
    else $error("accepted word did not start an update");

  // A word that causes no result leaves the block idle.
  a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !item_ok) |=> (state_r == S_IDLE))
    else $error("ignored word left the block busy");

  // The fill count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> (32'(cnt_new) <= RING_DEPTH))
    else $error("fill count beyond ring depth");

  // A finished result is loaded and the block returns to idle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result word not presented");
`endif

endmodule
